>>> hw/rtl/lru_keyed_table_keep_better_defines.svh
// assertion macros for the lru keyed table checker
// no dependencies
`ifndef LRU_KEYED_TABLE_KEEP_BETTER_DEFINES_SVH
`define LRU_KEYED_TABLE_KEEP_BETTER_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define LKTKB_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define LKTKB_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/lktkb_pkg.sv
// shared types and constants for the lru keyed table
// no dependencies
package lktkb_pkg;

    localparam int KEY_BITS    = 64;
    localparam int HDL_BITS    = 32;
    localparam int VISIT_BITS  = 32;
    localparam int CAP_BITS    = 5;
    localparam int OCC_BITS    = 5;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    typedef struct packed {
        logic [1:0]            operation;
        logic [KEY_BITS-1:0]   key;
        logic [HDL_BITS-1:0]   handle;
        logic [VISIT_BITS-1:0] visits;
    } t_in;

    typedef struct packed {
        logic                hit;
        logic [HDL_BITS-1:0] found_handle;
        logic                replaced;
        logic                evicted;
        logic [OCC_BITS-1:0] occupancy;
    } t_out;

    // per-transaction control broadcast along the cell row
    typedef struct packed {
        logic touch;
        logic insert;
        logic evict;
        logic clear;
    } t_cell_ctl;

endpackage

>>> hw/rtl/lktkb_cell.sv
// one entry of the recency-ordered row, position in the row is its recency rank
// depends on lktkb_pkg
module lktkb_cell #(
    parameter int HANDLE_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lktkb_pkg::t_cell_ctl             i_ctl,
    input  logic [lktkb_pkg::KEY_BITS-1:0]   i_key,
    input  logic                             i_deeper,
    input  logic                             i_prev_valid,
    input  logic [lktkb_pkg::KEY_BITS-1:0]   i_prev_key,
    input  logic [HANDLE_BITS-1:0]           i_prev_handle,
    input  logic [lktkb_pkg::VISIT_BITS-1:0] i_prev_visits,
    output logic                             o_match_any,
    output logic                             o_valid,
    output logic [lktkb_pkg::KEY_BITS-1:0]   o_key,
    output logic [HANDLE_BITS-1:0]           o_handle,
    output logic [lktkb_pkg::VISIT_BITS-1:0] o_visits
);
    import lktkb_pkg::*;

    logic                  r_valid;
    logic [KEY_BITS-1:0]   r_key;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [VISIT_BITS-1:0] r_visits;
    logic                  w_match;
    logic                  w_load;

    assign w_match     = r_valid && (r_key == i_key);
    assign o_match_any = w_match || i_deeper;

    // move to front shifts everything from the hit upward, insert shifts the valid prefix
    assign w_load = (i_ctl.touch && o_match_any) ||
                    (i_ctl.insert && i_prev_valid && (r_valid || !i_ctl.evict));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key    <= i_prev_key;
            r_handle <= i_prev_handle;
            r_visits <= i_prev_visits;
        end
    end

    assign o_valid  = r_valid;
    assign o_key    = r_key;
    assign o_handle = r_handle;
    assign o_visits = r_visits;

endmodule

>>> hw/rtl/lru_keyed_table_keep_better.sv
// Fully associative LRU table of 64-bit keys with handle and visit count per
// entry. For each transaction the key is compared against all cells of the row
// at once and the row shifts by one to bring the entry to the front, so one
// transaction is accepted per clock while the result register is free or being
// drained, and its result appears the cycle after acceptance.
// Cell 0 holds the most recent entry; the valid entries always form a prefix.
// depends on lktkb_pkg and lktkb_cell
module lru_keyed_table_keep_better #(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  lktkb_pkg::t_in                 i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output lktkb_pkg::t_out                o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lktkb_pkg::CAP_BITS-1:0] i_cfg_data
);
    import lktkb_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

    typedef logic [HANDLE_BITS-1:0] t_hdl;

    logic [CAP_BITS-1:0]    r_capacity;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    t_out                   r_out_data;
    t_out                   n_out_data;

    logic                   w_accept;
    t_cell_ctl              w_ctl;
    t_hdl                   w_in_hdl;
    logic                   w_null;
    logic                   w_hit;
    logic                   w_replace;
    logic                   w_evict;
    logic [CMPW-1:0]        w_cap;
    t_hdl                   w_sel_hdl;
    logic [VISIT_BITS-1:0]  w_sel_vis;
    t_hdl                   w_front_hdl;
    logic [VISIT_BITS-1:0]  w_front_vis;
    t_hdl                   w_found;

    logic                   w_any      [DEPTH+1];
    logic                   w_valid    [DEPTH];
    logic [KEY_BITS-1:0]    w_key      [DEPTH];
    t_hdl                   w_hdl      [DEPTH];
    logic [VISIT_BITS-1:0]  w_vis      [DEPTH];
    logic                   w_pvalid   [DEPTH];
    logic [KEY_BITS-1:0]    w_pkey     [DEPTH];
    t_hdl                   w_phdl     [DEPTH];
    logic [VISIT_BITS-1:0]  w_pvis     [DEPTH];

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_in_hdl = t_hdl'(i_in_data.handle);
    assign w_null   = (w_in_hdl == '0);
    assign w_hit    = w_any[0];

    always_comb begin
        w_sel_hdl = '0;
        w_sel_vis = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_any[i] && !w_any[i+1]) begin
                w_sel_hdl = w_sel_hdl | w_hdl[i];
                w_sel_vis = w_sel_vis | w_vis[i];
            end
        end
    end

    assign w_cap = (CMPW'(r_capacity) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(r_capacity);
    assign w_evict = (r_count != '0) && (CMPW'(r_count) >= w_cap);

    assign w_replace = (i_in_data.operation == OP_STORE) && w_hit && !w_null &&
                       (i_in_data.visits > w_sel_vis);

    always_comb begin
        w_ctl        = '0;
        w_ctl.evict  = w_evict;
        w_ctl.touch  = w_accept && w_hit &&
                       ((i_in_data.operation == OP_LOOKUP) ||
                        ((i_in_data.operation == OP_STORE) && !w_null));
        w_ctl.insert = w_accept && (i_in_data.operation == OP_STORE) && !w_hit && !w_null;
        w_ctl.clear  = w_accept && (i_in_data.operation == OP_CLEAR);
    end

    assign w_front_hdl = (w_ctl.insert || w_replace) ? w_in_hdl : w_sel_hdl;
    assign w_front_vis = (w_ctl.insert || w_replace) ? i_in_data.visits : w_sel_vis;

    assign w_any[DEPTH] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_front
                assign w_pvalid[g] = 1'b1;
                assign w_pkey[g]   = i_in_data.key;
                assign w_phdl[g]   = w_front_hdl;
                assign w_pvis[g]   = w_front_vis;
            end else begin : g_link
                assign w_pvalid[g] = w_valid[g-1];
                assign w_pkey[g]   = w_key[g-1];
                assign w_phdl[g]   = w_hdl[g-1];
                assign w_pvis[g]   = w_vis[g-1];
            end

            lktkb_cell #(
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_key         (i_in_data.key),
                .i_deeper      (w_any[g+1]),
                .i_prev_valid  (w_pvalid[g]),
                .i_prev_key    (w_pkey[g]),
                .i_prev_handle (w_phdl[g]),
                .i_prev_visits (w_pvis[g]),
                .o_match_any   (w_any[g]),
                .o_valid       (w_valid[g]),
                .o_key         (w_key[g]),
                .o_handle      (w_hdl[g]),
                .o_visits      (w_vis[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctl.clear) begin
            n_count = '0;
        end else if (w_ctl.insert && !w_evict) begin
            n_count = r_count + CW'(1);
        end
    end

    always_comb begin
        w_found = '0;
        case (i_in_data.operation)
            OP_LOOKUP: begin
                if (w_hit) begin
                    w_found = w_sel_hdl;
                end
            end
            OP_STORE: begin
                if (w_hit) begin
                    w_found = w_replace ? w_in_hdl : w_sel_hdl;
                end else if (!w_null) begin
                    w_found = w_in_hdl;
                end
            end
            default: begin
                w_found = '0;
            end
        endcase
    end

    always_comb begin
        n_out_data              = '0;
        n_out_data.hit          = w_hit && ((i_in_data.operation == OP_LOOKUP) ||
                                            (i_in_data.operation == OP_STORE));
        n_out_data.found_handle = HDL_BITS'(w_found);
        n_out_data.replaced     = w_replace;
        n_out_data.evicted      = w_ctl.insert && w_evict;
        n_out_data.occupancy    = OCC_BITS'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

>>> hw/rtl/lktkb_checker.sv
// port-level checks for the lru keyed table, bound to the top level
// depends on lktkb_pkg and lru_keyed_table_keep_better_defines.svh
`include "lru_keyed_table_keep_better_defines.svh"

module lktkb_checker #(
    parameter int DEPTH = 16
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input lktkb_pkg::t_in  i_in_data,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input lktkb_pkg::t_out o_out_data
);
    import lktkb_pkg::*;

    `LKTKB_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid,
        "result valid after reset")

    `LKTKB_ASSERT(a_clear_empties, i_clk, i_rst_n,
        (i_in_valid && !o_in_stall && i_in_data.operation == OP_CLEAR) |=>
        (o_out_valid && o_out_data.occupancy == '0 && !o_out_data.hit),
        "clear did not empty the table")

    `LKTKB_ASSERT(a_occ_bound, i_clk, i_rst_n,
        o_out_valid |-> (int'(o_out_data.occupancy) <= DEPTH),
        "occupancy above depth")

    `LKTKB_ASSERT(a_evict_miss, i_clk, i_rst_n,
        (o_out_valid && o_out_data.evicted) |-> (!o_out_data.hit && !o_out_data.replaced),
        "eviction on a hit")

    `LKTKB_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)),
        "stalled result changed")

endmodule

bind lru_keyed_table_keep_better lktkb_checker #(.DEPTH(DEPTH)) u_lktkb_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for lru_keyed_table_keep_better: directed and random lookups,
// stores and clears against an in-bench lru table, with capacity changes between phases
// depends on lktkb_pkg and the lru_keyed_table_keep_better rtl
module tb_top;
    import lktkb_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTED = 30;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_stall;
    t_in             i_in_data = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    t_out            o_out_data;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [CAP_BITS-1:0] i_cfg_data = '0;

    // lru table model
    logic [KEY_BITS-1:0]   lru_key    [TABLE_DEPTH];
    logic [HDL_BITS-1:0]   lru_handle [TABLE_DEPTH];
    logic [VISIT_BITS-1:0] lru_visits [TABLE_DEPTH];
    logic                  lru_valid  [TABLE_DEPTH] = '{default: 1'b0};
    int                    lru_rank   [TABLE_DEPTH] = '{default: 0};
    int                    lru_count = 0;
    int                    lru_cap = int'(CAP_RESET);

    t_in  item_q[$];
    t_out lookup_result_q[$];
    int   capacity_q[$];
    logic [KEY_BITS-1:0] key_pool [32];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int stuck_cycles = 0;

    lru_keyed_table_keep_better #(
        .DEPTH       (TABLE_DEPTH),
        .HANDLE_BITS (HDL_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic void make_newest(int s);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (lru_valid[i] && i != s && lru_rank[i] < lru_rank[s]) begin
                lru_rank[i]++;
            end
        end
        lru_rank[s] = 0;
    endfunction

    function automatic t_out table_apply(t_in item);
        t_out res;
        int   s;
        int   free_slot;
        int   lim;
        res = '0;
        s = -1;
        free_slot = -1;
        lim = (lru_cap > TABLE_DEPTH) ? TABLE_DEPTH : lru_cap;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (s < 0 && lru_valid[i] && lru_key[i] == item.key) begin
                s = i;
            end
        end
        case (item.operation)
            OP_LOOKUP: begin
                if (s >= 0) begin
                    res.hit = 1'b1;
                    res.found_handle = lru_handle[s];
                    make_newest(s);
                end
            end
            OP_STORE: begin
                if (s >= 0) begin
                    res.hit = 1'b1;
                    if (item.handle != '0) begin
                        if (item.visits > lru_visits[s]) begin
                            lru_handle[s] = item.handle;
                            lru_visits[s] = item.visits;
                            res.replaced = 1'b1;
                        end
                        make_newest(s);
                    end
                    res.found_handle = lru_handle[s];
                end else if (item.handle != '0) begin
                    // one eviction at most, even when capacity dropped below occupancy
                    if (lru_count >= lim && lru_count > 0) begin
                        for (int i = 0; i < TABLE_DEPTH; i++) begin
                            if (!res.evicted && lru_valid[i] && lru_rank[i] == lru_count - 1) begin
                                lru_valid[i] = 1'b0;
                                lru_count--;
                                res.evicted = 1'b1;
                            end
                        end
                    end
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
                        if (!lru_valid[i]) begin
                            free_slot = i;
                        end
                    end
                    if (free_slot >= 0) begin
                        for (int i = 0; i < TABLE_DEPTH; i++) begin
                            if (lru_valid[i]) begin
                                lru_rank[i]++;
                            end
                        end
                        lru_valid[free_slot] = 1'b1;
                        lru_key[free_slot] = item.key;
                        lru_handle[free_slot] = item.handle;
                        lru_visits[free_slot] = item.visits;
                        lru_rank[free_slot] = 0;
                        lru_count++;
                        res.found_handle = item.handle;
                    end
                end
            end
            OP_CLEAR: begin
                lru_valid = '{default: 1'b0};
                lru_rank = '{default: 0};
                lru_count = 0;
            end
            default: begin
            end
        endcase
        res.occupancy = OCC_BITS'(lru_count);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        end
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            report_mismatch(name, got, want);
        end
    endtask

    // lookup/store transaction driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                lookup_result_q.push_back(table_apply(i_in_data));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (item_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= item_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // capacity register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                lru_cap = int'(i_cfg_data);
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (capacity_q.size() != 0) begin
                    i_cfg_valid <= 1'b1;
                    i_cfg_data <= CAP_BITS'(capacity_q.pop_front());
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end
    end

    always @(posedge i_clk) begin : out_monitor
        t_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (lookup_result_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 64'(o_out_data), '0);
                end else begin
                    want = lookup_result_q.pop_front();
                    check_field("hit", 64'(o_out_data.hit), 64'(want.hit));
                    check_field("found_handle", 64'(o_out_data.found_handle),
                                64'(want.found_handle));
                    check_field("replaced", 64'(o_out_data.replaced), 64'(want.replaced));
                    check_field("evicted", 64'(o_out_data.evicted), 64'(want.evicted));
                    check_field("occupancy", 64'(o_out_data.occupancy),
                                64'(want.occupancy));
                end
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("lru_keyed_table_keep_better regression: fail");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        @(negedge i_clk);
        while (item_q.size() != 0 || i_in_valid || lookup_result_q.size() != 0 ||
               capacity_q.size() != 0 || i_cfg_valid) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_capacity(int value);
        wait_drained();
        capacity_q.push_back(value);
        wait_drained();
    endtask

    task automatic queue_item(logic [1:0] op, logic [KEY_BITS-1:0] key,
                              logic [HDL_BITS-1:0] handle, logic [VISIT_BITS-1:0] visits);
        t_in it;
        it.operation = op;
        it.key = key;
        it.handle = handle;
        it.visits = visits;
        item_q.push_back(it);
    endtask

    function automatic t_in random_item(int pool_n);
        t_in it;
        int  pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.operation = OP_LOOKUP;
        end else if (pick < 95) begin
            it.operation = OP_STORE;
        end else if (pick < 99) begin
            it.operation = OP_NOP;
        end else begin
            it.operation = OP_CLEAR;
        end
        if ($urandom_range(0, 19) == 0) begin
            it.key = {$urandom, $urandom};
        end else begin
            it.key = key_pool[$urandom_range(0, pool_n - 1)];
        end
        it.handle = ($urandom_range(0, 11) == 0) ? '0 : HDL_BITS'($urandom);
        case ($urandom_range(0, 3))
            0: it.visits = $urandom;
            3: it.visits = ($urandom_range(0, 7) == 0) ? '1 : $urandom_range(0, 15);
            default: it.visits = $urandom_range(0, 15);
        endcase
        return it;
    endfunction

    task automatic run_phase(int cap, int pool_n, int count, int tx_pct, int rx_pct,
                             bit hold_off);
        write_capacity(cap);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        if (hold_off) begin
            hold_req++;
        end
        for (int n = 0; n < count; n++) begin
            item_q.push_back(random_item(pool_n));
        end
        wait_drained();
    endtask

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 32; i++) begin
            key_pool[i] = {$urandom, $urandom};
        end
        @(negedge i_clk);
        while (!i_rst_n) begin
            @(negedge i_clk);
        end

        // directed: misses, keep-better rule, null stores, no-op, clear
        queue_item(OP_LOOKUP, '0, '0, '0);
        queue_item(OP_STORE, '0, '1, 32'd5);
        queue_item(OP_LOOKUP, '0, '0, '0);
        queue_item(OP_STORE, '0, 32'd1, 32'd5);
        queue_item(OP_STORE, '0, 32'd2, 32'd4);
        queue_item(OP_STORE, '0, 32'd3, 32'd6);
        queue_item(OP_STORE, '0, '0, '1);
        queue_item(OP_STORE, '1, '0, '1);
        queue_item(OP_STORE, '1, 32'h8000_0001, '1);
        queue_item(OP_STORE, '1, 32'd7, '1);
        queue_item(OP_NOP, '1, '1, '1);
        queue_item(OP_LOOKUP, '1, '1, '1);
        queue_item(OP_CLEAR, '1, '1, '1);
        queue_item(OP_LOOKUP, '1, '0, '0);
        wait_drained();

        // capacity zero still keeps one entry
        write_capacity(0);
        queue_item(OP_STORE, key_pool[2], 32'hA5A5_5A5A, 32'd1);
        queue_item(OP_STORE, key_pool[3], 32'h5A5A_A5A5, 32'd2);
        queue_item(OP_LOOKUP, key_pool[2], '0, '0);
        wait_drained();

        run_phase(16, 24, 150, 0, 0, 1'b0);
        run_phase(3, 6, 100, 78, 0, 1'b0);
        run_phase(31, 28, 150, 0, 78, 1'b0);
        run_phase(1, 3, 80, 16, 16, 1'b0);
        run_phase(8, 12, 120, 78, 0, 1'b0);
        run_phase(17, 20, 120, 16, 16, 1'b0);
        run_phase(0, 4, 60, 0, 78, 1'b0);
        run_phase(16, 32, 120, 0, 0, 1'b1);

        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0 && lookup_result_q.size() == 0) begin
            $display("lru_keyed_table_keep_better regression: pass");
        end else begin
            $display("lru_keyed_table_keep_better regression: fail");
        end
        $finish;
    end

endmodule
